// ===== rtl/grid_ray_wall_cast_macros.svh =====
// Assertion helpers used by the top-level RTL file.
`ifndef GRID_RAY_WALL_CAST_MACROS_SVH
`define GRID_RAY_WALL_CAST_MACROS_SVH

// condition in the same cycle
`define GRWC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// condition in the next cycle
`define GRWC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/grwc_pkg.sv =====
`default_nettype none
package grwc_pkg;

	localparam int MAP_SIZE       = 64;
	localparam int MAP_AW         = $clog2(MAP_SIZE);
	localparam int CELL_AW        = 2 * MAP_AW;
	localparam int MAP_DEPTH      = 1 << CELL_AW;
	localparam int MAX_WALK_STEPS = 128;
	localparam int STEP_W         = $clog2(MAX_WALK_STEPS + 1);
	// map coordinate, two's complement, room for one cell either side
	localparam int CRD_W          = (MAP_AW > 6 ? MAP_AW : 6) + 2;
	// signed distance numerator to a grid line, Q.16
	localparam int NUM_W          = CRD_W + 16;
	localparam int DIV_NW         = NUM_W + 15;
	localparam int DIV_DW         = 32;
	localparam int DIV_CW         = $clog2(DIV_NW + 1);
	// side distance accumulator
	localparam int SD_W           = 33 + STEP_W;

	localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
	localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
	localparam logic [1:0] REG_TEXTURE_WIDTH = 2'd2;

	localparam logic OP_MAP_WRITE = 1'b0;
	localparam logic OP_CAST      = 1'b1;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_CAM,
		S_RAY_X,
		S_RAY_Y,
		S_DELTA_X,
		S_DELTA_Y,
		S_SIDE_X,
		S_SIDE_Y,
		S_WALK,
		S_WALK_READ,
		S_DIST,
		S_HEIGHT,
		S_WALL_X,
		S_DONE
	} state_t;

	typedef struct packed {
		logic              start;
		logic [DIV_NW-1:0] num;
		logic [DIV_DW-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [DIV_NW-1:0] quo;
	} div_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/grwc_map_ram.sv =====
`default_nettype none
module grwc_map_ram import grwc_pkg::*; (
	input  wire logic               clk,
	input  wire logic               we,
	input  wire logic [CELL_AW-1:0] waddr,
	input  wire logic [7:0]         wdata,
	input  wire logic [CELL_AW-1:0] raddr,
	output logic      [7:0]         rdata
);

	logic [7:0] mem [MAP_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== rtl/grwc_div.sv =====
`default_nettype none
// restoring divider, one quotient bit a cycle
module grwc_div import grwc_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	logic [DIV_DW-1:0] rem_q;
	logic [DIV_NW-1:0] quo_q;
	logic [DIV_DW-1:0] den_q;
	logic [DIV_CW-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIV_DW:0]   trial;
	logic [DIV_DW:0]   diff;
	logic              fits;

	assign trial = {rem_q, quo_q[DIV_NW-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CW'(DIV_NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.num;
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
			quo_q <= {quo_q[DIV_NW-2:0], fits};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule
`default_nettype wire

// ===== rtl/grid_ray_wall_cast.sv =====
`default_nettype none
// channel  dir  handshake              word
// cfg      in   cfg_we                 cfg_index, cfg_data
// in       in   in_valid / in_stall    op, cell_x .. cell_value, column, pos_*, dir_*, plane_*
// out      out  out_valid / out_stall  hit_found .. texture_column
// After reset the map RAM is swept to zero, one cell a cycle, with in_stall high.
// Map write: written to the RAM as the word is accepted. Cast: up to five divisions in the shared divider (skipped
// for zero terms) plus one read on the map RAM read port per walk step, up to 128 steps.
// A finished word waits in the output register under out_stall; the next word is taken meanwhile.
`include "grid_ray_wall_cast_macros.svh"
module grid_ray_wall_cast import grwc_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [11:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               op,
	input  wire logic [5:0]         cell_x,
	input  wire logic [5:0]         cell_y,
	input  wire logic [7:0]         cell_value,
	input  wire logic [10:0]        column,
	input  wire logic [21:0]        pos_x,
	input  wire logic [21:0]        pos_y,
	input  wire logic signed [17:0] dir_x,
	input  wire logic signed [17:0] dir_y,
	input  wire logic signed [17:0] plane_x,
	input  wire logic signed [17:0] plane_y,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    hit_found,
	output logic                    hit_side,
	output logic [23:0]             wall_distance,
	output logic [15:0]             line_height,
	output logic [10:0]             draw_start,
	output logic [10:0]             draw_end,
	output logic [7:0]              wall_texture,
	output logic [7:0]              texture_column
);

	function automatic logic [11:0] clamp_size(input logic [11:0] v);
		if (v == 12'd0) return 12'd1;
		else if (v > 12'd2048) return 12'd2048;
		else return v;
	endfunction

	function automatic logic [8:0] clamp_tex(input logic [8:0] v);
		if (v == 9'd0) return 9'd1;
		else if (v > 9'd256) return 9'd256;
		else return v;
	endfunction

	function automatic logic [31:0] abs32(input logic [31:0] v);
		return v[31] ? (32'd0 - v) : v;
	endfunction

	state_t state_q, state_d;

	logic [11:0] cfg_w_q, cfg_h_q;
	logic [8:0]  cfg_tw_q;

	logic [CELL_AW-1:0] clr_cnt_q;
	logic               div_run_q;
	logic               out_valid_q;

	// cast working registers
	logic [10:0]        column_q;
	logic [21:0]        posx_q, posy_q;
	logic signed [17:0] dirx_q, diry_q, planex_q, planey_q;
	logic [11:0]        w_q, h_q;
	logic [8:0]         tw_q;
	logic signed [28:0] cam_q;
	logic [31:0]        rx_q, ry_q;
	logic [31:0]        ddx_q, ddy_q;
	logic [SD_W-1:0]    sdx_q, sdy_q;
	logic [CRD_W-1:0]   mx_q, my_q;
	logic [STEP_W-1:0]  step_cnt_q;
	logic               side_q, hit_q;
	logic [7:0]         cell_q;
	logic [23:0]        dist_q;
	logic [15:0]        lh_q;
	logic [15:0]        frac_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic               in_acc, out_free;
	logic               ram_we;
	logic [CELL_AW-1:0] ram_waddr, ram_raddr;
	logic [7:0]         ram_wdata, ram_rdata;
	logic [CRD_W-1:0]   wr_cx, wr_cy;

	// shared multipliers
	logic signed [17:0] ray_p, ray_d;
	logic signed [46:0] ray_prod;
	logic [31:0]        ray_val;
	logic [16:0]        side_f;
	logic [31:0]        side_dd;
	logic [48:0]        side_prod;

	// walk step
	logic               take_x;
	logic [CRD_W-1:0]   nmx, nmy;
	logic               n_in, start_in;

	// distance
	logic [31:0]        r_sel, r_other;
	logic [21:0]        pos_sel, pos_other;
	logic [CRD_W-1:0]   crd_sel;
	logic [MAP_AW:0]    line_crd;
	logic [NUM_W-1:0]   hit_num, num_mag;
	logic               dist_skip;
	logic [23:0]        dist_skip_val;
	logic [55:0]        wall_prod;

	// result
	logic [10:0]        half_h, ds_v, de_v;
	logic [14:0]        half_lh;
	logic [15:0]        de_sum;
	logic [24:0]        tex_prod;
	logic [8:0]         tex_v;
	logic               mirror;

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// map write port: clearing sweep after reset, else cell writes from the input
	assign wr_cx     = CRD_W'(cell_x);
	assign wr_cy     = CRD_W'(cell_y);
	assign ram_we    = (state_q == S_CLEAR) ||
		(in_acc && op == OP_MAP_WRITE && wr_cx < CRD_W'(MAP_SIZE) && wr_cy < CRD_W'(MAP_SIZE));
	assign ram_waddr = (state_q == S_CLEAR) ? clr_cnt_q :
		{wr_cx[MAP_AW-1:0], wr_cy[MAP_AW-1:0]};
	assign ram_wdata = (state_q == S_CLEAR) ? 8'd0 : cell_value;

	grwc_map_ram u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	grwc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign ray_p    = (state_q == S_RAY_Y) ? planey_q : planex_q;
	assign ray_d    = (state_q == S_RAY_Y) ? diry_q : dirx_q;
	assign ray_prod = ray_p * cam_q;
	assign ray_val  = {{14{ray_d[17]}}, ray_d} + {ray_prod[46], ray_prod[46:16]};

	always_comb begin
		if (state_q == S_SIDE_Y) begin
			side_f  = ry_q[31] ? {1'b0, posy_q[15:0]} : (17'h10000 - {1'b0, posy_q[15:0]});
			side_dd = ddy_q;
		end else begin
			side_f  = rx_q[31] ? {1'b0, posx_q[15:0]} : (17'h10000 - {1'b0, posx_q[15:0]});
			side_dd = ddx_q;
		end
	end
	assign side_prod = side_f * side_dd;

	assign take_x    = sdx_q < sdy_q;
	assign nmx       = take_x ? (rx_q[31] ? mx_q - 1'b1 : mx_q + 1'b1) : mx_q;
	assign nmy       = take_x ? my_q : (ry_q[31] ? my_q - 1'b1 : my_q + 1'b1);
	assign n_in      = !nmx[CRD_W-1] && nmx < CRD_W'(MAP_SIZE) &&
		!nmy[CRD_W-1] && nmy < CRD_W'(MAP_SIZE);
	assign ram_raddr = {nmx[MAP_AW-1:0], nmy[MAP_AW-1:0]};
	assign start_in  = CRD_W'(posx_q[21:16]) < CRD_W'(MAP_SIZE) &&
		CRD_W'(posy_q[21:16]) < CRD_W'(MAP_SIZE);

	assign r_sel     = side_q ? ry_q : rx_q;
	assign r_other   = side_q ? rx_q : ry_q;
	assign pos_sel   = side_q ? posy_q : posx_q;
	assign pos_other = side_q ? posx_q : posy_q;
	assign crd_sel   = side_q ? my_q : mx_q;
	// a backward step hits the far line of the cell
	assign line_crd  = (MAP_AW + 1)'(crd_sel[MAP_AW-1:0]) + (MAP_AW + 1)'(r_sel[31]);
	assign hit_num   = NUM_W'({line_crd, 16'd0}) - NUM_W'(pos_sel);
	assign num_mag   = hit_num[NUM_W-1] ? (NUM_W'(0) - hit_num) : hit_num;

	always_comb begin
		dist_skip     = 1'b1;
		dist_skip_val = 24'd0;
		if (r_sel == 32'd0) begin
			dist_skip_val = 24'hFFFFFF;
		end else if (hit_num == '0 || hit_num[NUM_W-1] != r_sel[31]) begin
			dist_skip_val = 24'd0;
		end else begin
			dist_skip = 1'b0;
		end
	end

	// only the fraction of the wall position is needed: low product bits suffice
	assign wall_prod = dist_q * r_other;

	assign half_h  = h_q[11:1];
	assign half_lh = lh_q[15:1];
	assign ds_v    = (15'(half_h) > half_lh) ? 11'(15'(half_h) - half_lh) : 11'd0;
	assign de_sum  = 16'(half_lh) + 16'(half_h);
	assign de_v    = (de_sum > 16'(h_q - 12'd1)) ? 11'(h_q - 12'd1) : de_sum[10:0];
	assign tex_prod = frac_q * tw_q;
	assign mirror  = (!side_q && !rx_q[31] && rx_q != 32'd0) || (side_q && ry_q[31]);
	assign tex_v   = mirror ? (tw_q - tex_prod[24:16] - 9'd1) : tex_prod[24:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		div_req.start = 1'b0;
		div_req.num   = '0;
		div_req.den   = '0;
		unique case (state_q)
			S_CLEAR: begin
				if (&clr_cnt_q) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_acc && op == OP_CAST) state_d = S_CAM;
			end
			S_CAM: begin
				div_req.num   = DIV_NW'({column_q, 17'd0});
				div_req.den   = DIV_DW'(w_q);
				div_req.start = !div_run_q;
				if (div_rsp.done) state_d = S_RAY_X;
			end
			S_RAY_X: state_d = S_RAY_Y;
			S_RAY_Y: state_d = S_DELTA_X;
			S_DELTA_X: begin
				if (rx_q == 32'd0) begin
					state_d = S_DELTA_Y;
				end else begin
					div_req.num   = DIV_NW'({1'b1, 32'd0});
					div_req.den   = abs32(rx_q);
					div_req.start = !div_run_q;
					if (div_rsp.done) state_d = S_DELTA_Y;
				end
			end
			S_DELTA_Y: begin
				if (ry_q == 32'd0) begin
					state_d = S_SIDE_X;
				end else begin
					div_req.num   = DIV_NW'({1'b1, 32'd0});
					div_req.den   = abs32(ry_q);
					div_req.start = !div_run_q;
					if (div_rsp.done) state_d = S_SIDE_X;
				end
			end
			S_SIDE_X: state_d = S_SIDE_Y;
			S_SIDE_Y: state_d = start_in ? S_WALK : S_DONE;
			S_WALK: begin
				if (step_cnt_q == STEP_W'(MAX_WALK_STEPS) || !n_in) state_d = S_DONE;
				else state_d = S_WALK_READ;
			end
			S_WALK_READ: state_d = (ram_rdata != 8'd0) ? S_DIST : S_WALK;
			S_DIST: begin
				if (dist_skip) begin
					state_d = S_HEIGHT;
				end else begin
					div_req.num   = {num_mag[NUM_W-2:0], 16'd0};
					div_req.den   = abs32(r_sel);
					div_req.start = !div_run_q;
					if (div_rsp.done) state_d = S_HEIGHT;
				end
			end
			S_HEIGHT: begin
				if (dist_q == 24'd0) begin
					state_d = S_WALL_X;
				end else begin
					div_req.num   = DIV_NW'({h_q, 16'd0});
					div_req.den   = DIV_DW'(dist_q);
					div_req.start = !div_run_q;
					if (div_rsp.done) state_d = S_WALL_X;
				end
			end
			S_WALL_X: state_d = S_DONE;
			S_DONE: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_w_q     <= 12'd640;
			cfg_h_q     <= 12'd480;
			cfg_tw_q    <= 9'd64;
			clr_cnt_q   <= '0;
			div_run_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_SCREEN_WIDTH:  cfg_w_q  <= cfg_data;
					REG_SCREEN_HEIGHT: cfg_h_q  <= cfg_data;
					REG_TEXTURE_WIDTH: cfg_tw_q <= cfg_data[8:0];
					default: ;
				endcase
			end
			if (state_q == S_CLEAR) clr_cnt_q <= clr_cnt_q + 1'b1;
			if (div_req.start) div_run_q <= 1'b1;
			else if (div_rsp.done) div_run_q <= 1'b0;
			if (state_q == S_DONE && out_free) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_acc && op == OP_CAST) begin
					column_q <= column;
					posx_q   <= pos_x;
					posy_q   <= pos_y;
					dirx_q   <= dir_x;
					diry_q   <= dir_y;
					planex_q <= plane_x;
					planey_q <= plane_y;
					w_q      <= clamp_size(cfg_w_q);
					h_q      <= clamp_size(cfg_h_q);
					tw_q     <= clamp_tex(cfg_tw_q);
					hit_q    <= 1'b0;
					side_q   <= 1'b0;
					cell_q   <= 8'd0;
				end
			end
			S_CAM: begin
				if (div_rsp.done) cam_q <= $signed(29'(div_rsp.quo)) - 29'sd65536;
			end
			S_RAY_X: rx_q <= ray_val;
			S_RAY_Y: ry_q <= ray_val;
			S_DELTA_X: begin
				if (rx_q == 32'd0) ddx_q <= '1;
				else if (div_rsp.done)
					ddx_q <= (|div_rsp.quo[DIV_NW-1:32]) ? '1 : div_rsp.quo[31:0];
			end
			S_DELTA_Y: begin
				if (ry_q == 32'd0) ddy_q <= '1;
				else if (div_rsp.done)
					ddy_q <= (|div_rsp.quo[DIV_NW-1:32]) ? '1 : div_rsp.quo[31:0];
			end
			S_SIDE_X: sdx_q <= SD_W'(side_prod[48:16]);
			S_SIDE_Y: begin
				sdy_q      <= SD_W'(side_prod[48:16]);
				mx_q       <= CRD_W'(posx_q[21:16]);
				my_q       <= CRD_W'(posy_q[21:16]);
				step_cnt_q <= '0;
			end
			S_WALK: begin
				if (step_cnt_q != STEP_W'(MAX_WALK_STEPS)) begin
					step_cnt_q <= step_cnt_q + 1'b1;
					mx_q       <= nmx;
					my_q       <= nmy;
					side_q     <= !take_x;
					if (take_x) sdx_q <= sdx_q + SD_W'(ddx_q);
					else sdy_q <= sdy_q + SD_W'(ddy_q);
				end
			end
			S_WALK_READ: begin
				if (ram_rdata != 8'd0) begin
					hit_q  <= 1'b1;
					cell_q <= ram_rdata;
				end
			end
			S_DIST: begin
				if (dist_skip) dist_q <= dist_skip_val;
				else if (div_rsp.done)
					dist_q <= (|div_rsp.quo[DIV_NW-1:24]) ? 24'hFFFFFF : div_rsp.quo[23:0];
			end
			S_HEIGHT: begin
				if (dist_q == 24'd0) lh_q <= 16'hFFFF;
				else if (div_rsp.done)
					lh_q <= (|div_rsp.quo[DIV_NW-1:16]) ? 16'hFFFF : div_rsp.quo[15:0];
			end
			S_WALL_X: frac_q <= pos_other[15:0] + wall_prod[31:16];
			S_DONE: begin
				if (out_free) begin
					hit_found      <= hit_q;
					hit_side       <= hit_q & side_q;
					wall_distance  <= hit_q ? dist_q : 24'd0;
					line_height    <= hit_q ? lh_q : 16'd0;
					draw_start     <= hit_q ? ds_v : 11'd0;
					draw_end       <= hit_q ? de_v : 11'd0;
					wall_texture   <= hit_q ? (cell_q - 8'd1) : 8'd0;
					texture_column <= hit_q ? tex_v[7:0] : 8'd0;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;

	`GRWC_ASSERT_IMPL(a_div_start_idle, clk, arst_n, div_req.start, !div_rsp.busy)
	`GRWC_ASSERT_IMPL(a_walk_bound, clk, arst_n, state_q == S_WALK_READ, step_cnt_q != '0 && step_cnt_q <= STEP_W'(MAX_WALK_STEPS))
	`GRWC_ASSERT_NEXT(a_done_holds, clk, arst_n, state_q == S_DONE && out_valid_q && out_stall, state_q == S_DONE)

endmodule
`default_nettype wire

// ===== bench/grid_ray_wall_cast_checker.sv =====
`default_nettype none
module grid_ray_wall_cast_checker import grwc_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [11:0]        cfg_data,
	input  wire logic               in_valid,
	input  wire logic               in_stall,
	input  wire logic               op,
	input  wire logic [5:0]         cell_x,
	input  wire logic [5:0]         cell_y,
	input  wire logic [7:0]         cell_value,
	input  wire logic [10:0]        column,
	input  wire logic [21:0]        pos_x,
	input  wire logic [21:0]        pos_y,
	input  wire logic signed [17:0] dir_x,
	input  wire logic signed [17:0] dir_y,
	input  wire logic signed [17:0] plane_x,
	input  wire logic signed [17:0] plane_y,
	input  wire logic               out_valid,
	input  wire logic               out_stall,
	input  wire logic               hit_found,
	input  wire logic               hit_side,
	input  wire logic [23:0]        wall_distance,
	input  wire logic [15:0]        line_height,
	input  wire logic [10:0]        draw_start,
	input  wire logic [10:0]        draw_end,
	input  wire logic [7:0]         wall_texture,
	input  wire logic [7:0]         texture_column,
	output int                      fails,
	output int                      pending
);

	localparam longint DELTA_SAT = 64'hFFFF_FFFF;
	localparam longint DIST_SAT  = 64'hFF_FFFF;

	typedef struct packed {
		logic        hit;
		logic        side;
		logic [23:0] wall_dist;
		logic [15:0] height;
		logic [10:0] span_lo;
		logic [10:0] span_hi;
		logic [7:0]  tex;
		logic [7:0]  tex_col;
	} wall_slice_t;

	wall_slice_t slices_due[$];
	logic [7:0]  map_copy [MAP_DEPTH];
	logic [11:0] width_reg, height_reg;
	logic [8:0]  texw_reg;

	assign pending = slices_due.size();

	function automatic longint clamp_to(longint v, longint hi);
		if (v == 0)
			return 1;
		return v > hi ? hi : v;
	endfunction

	function automatic longint inverse_step(longint r);
		longint q;
		if (r == 0)
			return DELTA_SAT;
		q = (64'd1 << 32) / (r < 0 ? -r : r);
		return q > DELTA_SAT ? DELTA_SAT : q;
	endfunction

	function automatic longint perp_distance(longint num, longint r);
		longint q;
		if (r == 0)
			return DIST_SAT;
		if (num == 0 || ((num < 0) != (r < 0)))
			return 0;
		q = ((num < 0 ? -num : num) << 16) / (r < 0 ? -r : r);
		return q > DIST_SAT ? DIST_SAT : q;
	endfunction

	function automatic wall_slice_t cast_column(logic [10:0] col, logic [21:0] px,
			logic [21:0] py, logic signed [17:0] dx, logic signed [17:0] dy,
			logic signed [17:0] plx, logic signed [17:0] ply);
		wall_slice_t r;
		longint w, h, tw, cam, rx, ry, ddx, ddy, sdx, sdy, fx, fy;
		longint num, perp_d, lh, ds, de, wx, texx;
		int mx, my, sx, sy, side, i;
		logic hit;
		logic [7:0] hit_cell;
		r = '0;
		hit = 0;
		side = 0;
		hit_cell = 0;
		w = clamp_to(width_reg, 2048);
		h = clamp_to(height_reg, 2048);
		tw = clamp_to(texw_reg, 256);
		cam = ((longint'(col) * 2) << 16) / w - 65536;
		rx = longint'(dx) + ((longint'(plx) * cam) >>> 16);
		ry = longint'(dy) + ((longint'(ply) * cam) >>> 16);
		mx = int'(px >> 16);
		my = int'(py >> 16);
		ddx = inverse_step(rx);
		ddy = inverse_step(ry);
		fx = longint'(px[15:0]);
		fy = longint'(py[15:0]);
		if (rx < 0) begin
			sx = -1; sdx = (fx * ddx) >> 16;
		end else begin
			sx = 1; sdx = ((65536 - fx) * ddx) >> 16;
		end
		if (ry < 0) begin
			sy = -1; sdy = (fy * ddy) >> 16;
		end else begin
			sy = 1; sdy = ((65536 - fy) * ddy) >> 16;
		end
		if (mx < MAP_SIZE && my < MAP_SIZE) begin
			for (i = 0; i < MAX_WALK_STEPS; i++) begin
				if (sdx < sdy) begin
					sdx += ddx; mx += sx; side = 0;
				end else begin
					sdy += ddy; my += sy; side = 1;
				end
				if (mx < 0 || mx >= MAP_SIZE || my < 0 || my >= MAP_SIZE)
					break;
				hit_cell = map_copy[mx * MAP_SIZE + my];
				if (hit_cell != 0) begin
					hit = 1;
					break;
				end
			end
		end
		if (!hit)
			return r;
		if (side == 0) begin
			num = ((longint'(mx) + (sx < 0 ? 1 : 0)) << 16) - longint'(px);
			perp_d = perp_distance(num, rx);
		end else begin
			num = ((longint'(my) + (sy < 0 ? 1 : 0)) << 16) - longint'(py);
			perp_d = perp_distance(num, ry);
		end
		if (perp_d == 0)
			lh = 65535;
		else begin
			lh = (h << 16) / perp_d;
			if (lh > 65535)
				lh = 65535;
		end
		ds = h / 2 - lh / 2;
		if (ds < 0)
			ds = 0;
		de = lh / 2 + h / 2;
		if (de > h - 1)
			de = h - 1;
		if (side == 0)
			wx = longint'(py) + ((perp_d * ry) >>> 16);
		else
			wx = longint'(px) + ((perp_d * rx) >>> 16);
		texx = (longint'(wx[15:0]) * tw) >> 16;
		// mirrored so the texture reads the same way from both faces
		if ((side == 0 && rx > 0) || (side == 1 && ry < 0))
			texx = tw - texx - 1;
		r.hit = 1;
		r.side = side[0];
		r.wall_dist = perp_d[23:0];
		r.height = lh[15:0];
		r.span_lo = ds[10:0];
		r.span_hi = de[10:0];
		r.tex = hit_cell - 8'd1;
		r.tex_col = texx[7:0];
		return r;
	endfunction

	function automatic int check_field(string name, longint want, longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		wall_slice_t due;
		int bad;
		if (!arst_n) begin
			for (int i = 0; i < MAP_DEPTH; i++)
				map_copy[i] = '0;
			width_reg <= 12'd640;
			height_reg <= 12'd480;
			texw_reg <= 9'd64;
			slices_due.delete();
			fails <= 0;
		end else begin
			bad = 0;
			if (cfg_we) begin
				case (cfg_index)
				REG_SCREEN_WIDTH: begin
					width_reg <= cfg_data;
				end
				REG_SCREEN_HEIGHT: begin
					height_reg <= cfg_data;
				end
				REG_TEXTURE_WIDTH: begin
					texw_reg <= cfg_data[8:0];
				end
				default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (slices_due.size() == 0) begin
					$error("result word with nothing expected");
					bad++;
				end else begin
					due = slices_due.pop_front();
					bad += check_field("hit_found", due.hit, hit_found);
					bad += check_field("hit_side", due.side, hit_side);
					bad += check_field("wall_distance", due.wall_dist, wall_distance);
					bad += check_field("line_height", due.height, line_height);
					bad += check_field("draw_start", due.span_lo, draw_start);
					bad += check_field("draw_end", due.span_hi, draw_end);
					bad += check_field("wall_texture", due.tex, wall_texture);
					bad += check_field("texture_column", due.tex_col, texture_column);
				end
			end
			if (in_valid && !in_stall) begin
				if (op == OP_MAP_WRITE)
					map_copy[int'(cell_x) * MAP_SIZE + int'(cell_y)] = cell_value;
				else
					slices_due.push_back(cast_column(column, pos_x, pos_y, dir_x, dir_y,
						plane_x, plane_y));
			end
			if (bad != 0)
				fails <= fails + bad;
		end
	end

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
`default_nettype none
module testbench import grwc_pkg::*;;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int SETTLE      = 600;

	logic               clk = 0;
	logic               arst_n = 0;
	logic               cfg_we = 0;
	logic [1:0]         cfg_index = '0;
	logic [11:0]        cfg_data = '0;
	logic               in_valid = 0;
	logic               in_stall;
	logic               op = OP_MAP_WRITE;
	logic [5:0]         cell_x = '0, cell_y = '0;
	logic [7:0]         cell_value = '0;
	logic [10:0]        column = '0;
	logic [21:0]        pos_x = '0, pos_y = '0;
	logic signed [17:0] dir_x = '0, dir_y = '0, plane_x = '0, plane_y = '0;
	logic               out_valid;
	logic               out_stall = 0;
	logic               hit_found, hit_side;
	logic [23:0]        wall_distance;
	logic [15:0]        line_height;
	logic [10:0]        draw_start, draw_end;
	logic [7:0]         wall_texture, texture_column;
	int                 fails, pending;
	int                 cycles = 0;
	logic               quiet = 0;
	logic               hold_long = 0;

	grid_ray_wall_cast dut (.*);
	grid_ray_wall_cast_checker checker_i (.*);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// result side back-pressure
	initial begin
		forever begin
			@(negedge clk);
			if (hold_long) begin
				out_stall = 1;
				repeat (1200) @(negedge clk);
				out_stall = 0;
				hold_long = 0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				out_stall = 1;
				repeat ($urandom_range(1, 16)) @(negedge clk);
				out_stall = 0;
			end
		end
	end

	task automatic offer_word();
		if (!quiet && $urandom_range(0, 7) == 0) begin
			in_valid = 0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		in_valid = 1;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
		in_valid = 0;
	endtask

	task automatic put_cell(int x, int y, int v);
		op = OP_MAP_WRITE;
		cell_x = x[5:0];
		cell_y = y[5:0];
		cell_value = v[7:0];
		offer_word();
	endtask

	task automatic cast_ray(int col, logic [21:0] px, logic [21:0] py,
			int dx, int dy, int plx, int ply);
		op = OP_CAST;
		column = col[10:0];
		pos_x = px;
		pos_y = py;
		dir_x = dx[17:0];
		dir_y = dy[17:0];
		plane_x = plx[17:0];
		plane_y = ply[17:0];
		offer_word();
	endtask

	task automatic random_cast(logic in_box);
		logic [21:0] px, py;
		px = 22'($urandom);
		py = 22'($urandom);
		if (in_box) begin
			px[21:16] = 6'($urandom_range(1, 14));
			py[21:16] = 6'($urandom_range(1, 14));
		end
		cast_ray($urandom_range(0, 2047), px, py, $urandom, $urandom, $urandom, $urandom);
	endtask

	// registers change only once the block has drained
	task automatic write_reg(logic [1:0] idx, int v);
		wait (pending == 0);
		repeat (SETTLE) @(negedge clk);
		cfg_index = idx;
		cfg_data = v[11:0];
		cfg_we = 1;
		@(negedge clk);
		cfg_we = 0;
	endtask

	task automatic screen_setup(int w, int h, int tw);
		write_reg(REG_SCREEN_WIDTH, w);
		write_reg(REG_SCREEN_HEIGHT, h);
		write_reg(REG_TEXTURE_WIDTH, tw);
	endtask

	initial begin
		repeat (2) @(negedge clk);
		arst_n = 1;

		// directed words at reset register values
		put_cell(5, 5, 255);
		put_cell(63, 0, 1);
		put_cell(0, 63, 2);
		put_cell(63, 63, 128);
		put_cell(0, 0, 0);
		cast_ray(320, 22'h02_0000, 22'h05_8000, 65536, 0, 0, 0);
		cast_ray(0, 22'h02_0000, 22'h05_8000, 0, 0, 0, 0);
		cast_ray(2047, 22'h3F_FFFF, 22'h3F_FFFF, -131072, -131072, 131071, -131072);
		cast_ray(0, 22'h00_0000, 22'h00_0000, 131071, 131071, -131072, 131071);
		cast_ray(639, 22'h05_0000, 22'h02_0000, 0, 65536, 0, 0);
		cast_ray(100, 22'h05_8000, 22'h07_0000, 0, -65536, 43000, 0);
		cast_ray(640, 22'h3E_8000, 22'h00_4000, 65536, -20000, 0, 43000);
		put_cell(5, 5, 0);
		cast_ray(320, 22'h02_0000, 22'h05_8000, 65536, 0, 0, 0);

		// closed room 0..15 with random wall textures
		screen_setup(320, 200, 64);
		for (int k = 0; k < 16; k++) begin
			put_cell(k, 0, $urandom_range(1, 255));
			put_cell(k, 15, $urandom_range(1, 255));
			put_cell(0, k, $urandom_range(1, 255));
			put_cell(15, k, $urandom_range(1, 255));
		end
		for (int n = 0; n < 120; n++) begin
			if (n == 40)
				hold_long = 1;
			if ($urandom_range(0, 4) == 0)
				put_cell($urandom_range(1, 14), $urandom_range(1, 14),
					$urandom_range(0, 1) ? 0 : $urandom_range(0, 255));
			else
				random_cast(1);
		end

		screen_setup(1, 1, 1);
		repeat (40) random_cast(1);

		screen_setup(2048, 2048, 256);
		repeat (40) random_cast(1);

		// out-of-range register values saturate
		screen_setup(0, 4095, 4095);
		write_reg(2'd3, 12'hABC);
		repeat (30) random_cast(1);

		screen_setup(777, 1023, 100);
		for (int n = 0; n < 120; n++) begin
			if (n == 60) begin
				wait (pending == 0);
				quiet = 1;
			end
			if ($urandom_range(0, 9) < 3)
				put_cell($urandom, $urandom, $urandom_range(0, 3) == 0 ? 0 : $urandom);
			else
				random_cast($urandom_range(0, 1));
		end

		wait (pending == 0);
		repeat (SETTLE) @(negedge clk);
		if (fails == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
`default_nettype wire
